/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file ddd_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* design/ddd_pkg.sv */
// ----------------------------------------------------------------------------
// ddd_pkg
// Types, constants and calendar tables for the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

  localparam int DAY_W   = 7;
  localparam int MONTH_W = 7;
  localparam int YEAR_W  = 14;
  localparam int DNUM_W  = 23;
  localparam int DIFF_W  = 23;
  localparam int ORDER_W = 2;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 32;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x below 43699
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic signed [DIFF_W:0] DIFF_LIMIT = 24'sd3652425;

  localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd2;

  localparam logic [3:0] MONTH_FEB = 4'd1;  // zero-based index

  typedef struct packed {
    logic en_s1;
    logic en_s2;
  } ddd_ctrl_t;

  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] r;
    case (idx)
      4'd1:                  r = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
      default:               r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

/* design/ddd_lane.sv */
// ----------------------------------------------------------------------------
// ddd_lane
// One date: validity check and day number, two register stages.
// ----------------------------------------------------------------------------
module ddd_lane
  import ddd_pkg::*;
(
  input  logic               clk,
  input  ddd_ctrl_t          ctrl,
  input  logic [DAY_W-1:0]   day,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output logic [DNUM_W-1:0]  day_num,
  output logic               date_ok
);

  // stage 1 combinational
  logic [14:0] y_p99;
  logic [14:0] y_p399;
  logic [12:0] y_p399_q4;
  logic [27:0] p100;
  logic [25:0] p400;
  logic [26:0] pq;

  // stage 1 registers
  logic [YEAR_W-1:0] s1_year;
  logic [12:0]       s1_y4;
  logic [7:0]        s1_c100;
  logic [5:0]        s1_c400;
  logic [7:0]        s1_q100;
  logic [3:0]        s1_midx;
  logic              s1_mok;
  logic [DAY_W-1:0]  s1_day;

  // stage 2 combinational
  logic             leap;
  logic [4:0]       mlen;
  logic             ok_next;
  logic [DNUM_W-1:0] dn_next;
  logic             adj;

  always_comb begin
    y_p99     = {1'b0, year} + 15'd99;
    y_p399    = {1'b0, year} + 15'd399;
    y_p399_q4 = y_p399[14:2];
    p100      = 28'(y_p99) * 28'(DIV100_MUL);
    p400      = 26'(y_p399_q4) * 26'(DIV100_MUL);
    pq        = 27'(year) * 27'(DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_s1) begin
      s1_year <= year;
      s1_y4   <= 13'(({1'b0, year} + 15'd3) >> 2);
      s1_c100 <= p100[DIV100_SHIFT +: 8];
      s1_c400 <= p400[DIV100_SHIFT +: 6];
      s1_q100 <= pq[DIV100_SHIFT +: 8];
      s1_midx <= 4'(month - 7'd1);
      s1_mok  <= (month >= 7'd1) && (month <= 7'd12);
      s1_day  <= day;
    end
  end

  always_comb begin
    // divisible by 4, and either not by 100 or the century by 4
    leap = (s1_year[1:0] == 2'b00) &&
           ((14'(s1_q100) * 14'd100 != s1_year) || (s1_q100[1:0] == 2'b00));
    mlen = month_len(s1_midx, leap);
    ok_next = s1_mok && (s1_day != '0) && (s1_day <= DAY_W'(mlen));
    adj = leap && (s1_midx > MONTH_FEB);
    dn_next = DNUM_W'(s1_year) * DNUM_W'(365) + DNUM_W'(s1_y4) - DNUM_W'(s1_c100)
            + DNUM_W'(s1_c400) + DNUM_W'(month_start(s1_midx)) + DNUM_W'(s1_day)
            + DNUM_W'(adj);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_s2) begin
      day_num <= dn_next;
      date_ok <= ok_next;
    end
  end

endmodule

/* design/ddd_merge.sv */
// ----------------------------------------------------------------------------
// ddd_merge
// Combines the two lanes: difference, order, saturation, output register.
// ----------------------------------------------------------------------------
module ddd_merge
  import ddd_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [DNUM_W-1:0]        dn_first,
  input  logic                     ok_first,
  input  logic [DNUM_W-1:0]        dn_second,
  input  logic                     ok_second,
  output logic signed [DIFF_W-1:0] day_difference,
  output logic [ORDER_W-1:0]       order,
  output logic                     dates_valid
);

  logic signed [DIFF_W:0]  diff;
  logic signed [DIFF_W:0]  sat;
  logic                    ok;
  logic [ORDER_W-1:0]      ord;

  always_comb begin
    diff = $signed({1'b0, dn_second}) - $signed({1'b0, dn_first});
    ok   = ok_first && ok_second;
    if (diff > DIFF_LIMIT) begin
      sat = DIFF_LIMIT;
    end else if (diff < -DIFF_LIMIT) begin
      sat = -DIFF_LIMIT;
    end else begin
      sat = diff;
    end
    if (!ok || diff == '0) begin
      ord = ORDER_EQUAL;
    end else if (diff[DIFF_W]) begin
      ord = ORDER_LATER;
    end else begin
      ord = ORDER_EARLIER;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_difference <= ok ? sat[DIFF_W-1:0] : '0;
      order          <= ord;
      dates_valid    <= ok;
    end
  end

endmodule

/* design/date_difference_in_days.sv */
// ----------------------------------------------------------------------------
// date_difference_in_days
// Days between two Gregorian dates, with order and validity.
// ----------------------------------------------------------------------------
// Input channel s_axis carries one date pair per item; output channel m_axis
// returns one result per item, in order. Two lanes, one per date, check the
// date and form its day number; a merge stage subtracts, saturates to
// +/-3652425 days and gives the order. An invalid date gives a difference of
// 0, order equal and dates_valid low.
// Path: lane stage 1, lane stage 2, output register. Throughput: one item per
// cycle unless m_axis stalls; lane stages and output register hold one each.
// A stall on m_axis holds the result in the output register; items still
// enter until the two lane stages behind it are full, then s_axis_tready
// drops. Bubbles are squeezed out as the pipeline refills.
// Reset (rst, synchronous) empties the pipeline: m_axis_tvalid goes low and
// s_axis_tready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module date_difference_in_days
  import ddd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // first_day[6:0], first_month[13:7], first_year[27:14],
  // second_day[34:28], second_month[41:35], second_year[55:42]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // day_difference[22:0] (signed), order[24:23], dates_valid[25], zero above
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic v1;
  logic v2;
  logic vo;
  logic rdy_out;
  logic rdy2;
  logic rdy1;

  ddd_ctrl_t ctrl;

  logic [DNUM_W-1:0]        dn_a;
  logic [DNUM_W-1:0]        dn_b;
  logic                     ok_a;
  logic                     ok_b;
  logic signed [DIFF_W-1:0] day_difference;
  logic [ORDER_W-1:0]       order;
  logic                     dates_valid;

  always_comb begin
    rdy_out    = !vo || m_axis_tready;
    rdy2       = !v2 || rdy_out;
    rdy1       = !v1 || rdy2;
    ctrl.en_s1 = rdy1;
    ctrl.en_s2 = rdy2;
  end

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {{(OUT_W - DIFF_W - ORDER_W - 1){1'b0}}, dates_valid, order,
                          day_difference};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy_out) begin
        vo <= v2;
      end
    end
  end

  ddd_lane u_lane_first (
    .clk     (clk),
    .ctrl    (ctrl),
    .day     (s_axis_tdata[6:0]),
    .month   (s_axis_tdata[13:7]),
    .year    (s_axis_tdata[27:14]),
    .day_num (dn_a),
    .date_ok (ok_a)
  );

  ddd_lane u_lane_second (
    .clk     (clk),
    .ctrl    (ctrl),
    .day     (s_axis_tdata[34:28]),
    .month   (s_axis_tdata[41:35]),
    .year    (s_axis_tdata[55:42]),
    .day_num (dn_b),
    .date_ok (ok_b)
  );

  ddd_merge u_merge (
    .clk            (clk),
    .en             (rdy_out),
    .dn_first       (dn_a),
    .ok_first       (ok_a),
    .dn_second      (dn_b),
    .ok_second      (ok_b),
    .day_difference (day_difference),
    .order          (order),
    .dates_valid    (dates_valid)
  );

endmodule

/* design/ddd_checker.sv */
// ----------------------------------------------------------------------------
// ddd_checker
// Port-level checks on the date difference block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddd_checker
  import ddd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic [DIFF_W-1:0]  diff;
  logic [ORDER_W-1:0] ord;
  logic               ok;

  assign diff = m_axis_tdata[DIFF_W-1:0];
  assign ord  = m_axis_tdata[DIFF_W +: ORDER_W];
  assign ok   = m_axis_tdata[DIFF_W + ORDER_W];

  // pipeline is empty right after reset
  `ASSERT_ALWAYS(a_empty_after_rst, clk, (!rst && $past(rst)) |-> !m_axis_tvalid)

  `ASSERT_CLK(a_invalid_zero, clk, rst,
    (m_axis_tvalid && !ok) |-> (diff == '0 && ord == ORDER_EQUAL))

  `ASSERT_CLK(a_equal_zero, clk, rst, (m_axis_tvalid && ord == ORDER_EQUAL) |-> diff == '0)

  `ASSERT_CLK(a_order_sign, clk, rst,
    (m_axis_tvalid && ok && ord == ORDER_EARLIER) |-> (!diff[DIFF_W-1] && diff != '0))

  `ASSERT_CLK(a_hold_stall, clk, rst,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (.*);
